### sv/chc_pkg.sv
// Shared types, constants and helpers for the canonical Huffman codebook.
// Used by chc_table, chc_unit and canonical_huffman_codebook; depends on nothing.
package chc_pkg;

    // Default sizing
    localparam int SYMBOLS_DEF = 128;
    localparam int MAX_LEN_DEF = 32;

    // Field widths
    localparam int MODE_W = 2;
    localparam int SYM_W  = 7;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;

    // Longest storable code and widest decode count
    localparam int LEN_CAP   = 32;
    localparam int COUNT_CAP = 63;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    // Shared unit operations
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_KRAFT = 2'd1;
    localparam logic [1:0] OP_NEG   = 2'd2;
    localparam logic [1:0] OP_RANK  = 2'd3;

    // Per-cycle command to the shared unit
    typedef struct packed {
        logic [1:0] op;
        logic       first;
        logic       tie;
    } chc_ctl_t;

    // Mask of the low len bits, len from 0 to 32
    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return ~({CODE_W{1'b1}} << len);
    endfunction

endpackage

### sv/chc_table.sv
// Code length store: one write port, one registered read port, per-entry valid bits.
// Depends on chc_pkg.
module chc_table #(
    parameter int SYMBOLS = chc_pkg::SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(SYMBOLS)-1:0]   wr_addr,
    input  logic [chc_pkg::LEN_W-1:0]    wr_len,
    input  logic [$clog2(SYMBOLS)-1:0]   rd_addr,
    output logic [chc_pkg::LEN_W-1:0]    rd_len,
    output logic [$clog2(SYMBOLS)-1:0]   rd_idx
);
    import chc_pkg::*;

    localparam int IDX_W = $clog2(SYMBOLS);

    logic [LEN_W-1:0] mem [SYMBOLS];
    logic [SYMBOLS-1:0] valid_reg;
    logic [LEN_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Write the entry and read the addressed one
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_len;
        end
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // Mark written entries; an entry never written reads as absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_len = rd_vld_reg ? rd_data_reg : '0;
    assign rd_idx = rd_idx_reg;

endmodule

### sv/chc_unit.sv
// Shared accumulate unit: one adder that sums code space, negates and counts rank.
// Depends on chc_pkg.
module chc_unit #(
    parameter int SYMBOLS = chc_pkg::SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  chc_pkg::chc_ctl_t            ctl,
    input  logic [chc_pkg::LEN_W-1:0]    ent_len,
    input  logic [$clog2(SYMBOLS)-1:0]   ent_idx,
    input  logic [chc_pkg::LEN_W-1:0]    tgt_len,
    input  logic [$clog2(SYMBOLS)-1:0]   tgt_sym,
    input  logic [chc_pkg::CODE_W-1:0]   bits,
    output logic [chc_pkg::CODE_W-1:0]   acc,
    output logic                         hit
);
    import chc_pkg::*;

    logic [CODE_W-1:0] acc_reg;
    logic [CODE_W-1:0] acc_next;
    logic [CODE_W-1:0] opa;
    logic [CODE_W-1:0] opb;
    logic              cin;
    logic              en;
    logic              take;
    logic              same_len;
    logic [4:0]        sh;
    logic [CODE_W-1:0] sum;

    // Entry counts toward the code space below the target
    assign same_len = (ent_len == tgt_len) && (ent_len != '0);
    assign take = (ent_len != '0) &&
                  ((ent_len < tgt_len) || (ctl.tie && same_len && (ent_idx < tgt_sym)));
    assign sh = 5'(tgt_len - ent_len);

    // Select operands for the single adder
    always_comb
    begin
        opa = acc_reg;
        opb = '0;
        cin = 1'b0;
        en  = 1'b0;
        case (ctl.op)
            OP_KRAFT:
            begin
                opa = ctl.first ? '0 : acc_reg;
                opb = take ? (CODE_W'(1) << sh) : '0;
                en  = 1'b1;
            end
            OP_NEG:
            begin
                opa = bits;
                opb = ~acc_reg;
                cin = 1'b1;
                en  = 1'b1;
            end
            OP_RANK:
            begin
                opb = '1;
                en  = same_len;
            end
            default:
            begin
                en = 1'b0;
            end
        endcase
    end

    assign sum      = opa + opb + {{(CODE_W-1){1'b0}}, cin};
    assign acc_next = en ? sum : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Rank reached zero on a code of the target length
    assign hit = (ctl.op == OP_RANK) && same_len && ((acc_reg & len_mask(tgt_len)) == '0);
    assign acc = acc_reg;

endmodule

### sv/canonical_huffman_codebook.sv
// Canonical Huffman codebook top level: request sequencer, decode state, result register.
// Depends on chc_pkg, chc_table and chc_unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  request  | req_valid, req_stall | mode, symbol, code_length, coded_bit
//  result   | res_valid, res_stall | codeword, length_out, symbol_out, valid_res, error
//
// Write and unused requests go straight to the result stage. A codeword read makes one pass of
// the length table through the shared adder. A decode bit makes two passes (one sums shorter
// code space, one counts rank), or none once the bit count passes 32. Length table read port
// sets the pace, one entry a cycle.
// Reset clears the table valid bits and decode state at once; no clearing pass.
// req_stall is high from acceptance until the result enters the result register;
// a request is taken while an earlier result still waits under res_stall.
module canonical_huffman_codebook #(
    parameter int SYMBOLS = chc_pkg::SYMBOLS_DEF,
    parameter int MAX_LEN = chc_pkg::MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [chc_pkg::MODE_W-1:0]   mode,
    input  logic [chc_pkg::SYM_W-1:0]    symbol,
    input  logic [chc_pkg::LEN_W-1:0]    code_length,
    input  logic                         coded_bit,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [chc_pkg::CODE_W-1:0]   codeword,
    output logic [chc_pkg::LEN_W-1:0]    length_out,
    output logic [chc_pkg::SYM_W-1:0]    symbol_out,
    output logic                         valid_res,
    output logic                         error
);
    import chc_pkg::*;

    localparam int IDX_W = $clog2(SYMBOLS);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'((MAX_LEN < COUNT_CAP) ? MAX_LEN : COUNT_CAP);
    localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(LEN_CAP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOLS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LKLEN = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              lookup_reg, lookup_next;
    logic              pass_reg, pass_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  sym_reg, sym_next;
    logic [CODE_W-1:0] bits_reg, bits_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    chc_ctl_t          ctl_reg, ctl_next;

    logic [CODE_W-1:0] pcode_reg, pcode_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [SYM_W-1:0]  psym_reg, psym_next;
    logic              pvld_reg, pvld_next;
    logic              perr_reg, perr_next;

    logic              res_valid_reg, res_valid_next;
    logic [CODE_W-1:0] codeword_reg, codeword_next;
    logic [LEN_W-1:0]  length_out_reg, length_out_next;
    logic [SYM_W-1:0]  symbol_out_reg, symbol_out_next;
    logic              valid_res_reg, valid_res_next;
    logic              error_reg, error_next;

    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    logic [LEN_W-1:0]  tbl_rd_len;
    logic [IDX_W-1:0]  tbl_rd_idx;
    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] u_acc;
    logic              u_hit;
    logic              sym_ok;
    logic [IDX_W-1:0]  sym_idx;
    logic [CODE_W-1:0] bits_new;
    logic [LEN_W-1:0]  count_new;

    chc_table #(
        .SYMBOLS (SYMBOLS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (sym_idx),
        .wr_len  (wr_len),
        .rd_addr (tbl_rd_addr),
        .rd_len  (tbl_rd_len),
        .rd_idx  (tbl_rd_idx)
    );

    chc_unit #(
        .SYMBOLS (SYMBOLS)
    ) u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .ent_len (tbl_rd_len),
        .ent_idx (tbl_rd_idx),
        .tgt_len (len_reg),
        .tgt_sym (sym_reg),
        .bits    (bits_reg),
        .acc     (u_acc),
        .hit     (u_hit)
    );

    // Decode request fields
    assign sym_ok    = 32'(symbol) < 32'(SYMBOLS);
    assign sym_idx   = IDX_W'(symbol);
    assign wr_len    = (code_length > LEN_TOP) ? LEN_TOP : code_length;
    assign bits_new  = {bits_reg[CODE_W-2:0], coded_bit};
    assign count_new = count_reg + LEN_W'(1);

    // Sequence one request through the table and the shared unit
    always_comb
    begin
        state_next  = state_reg;
        lookup_next = lookup_reg;
        pass_next   = pass_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        sym_next    = sym_reg;
        bits_next   = bits_reg;
        count_next  = count_reg;
        ctl_next    = '{op: OP_IDLE, first: 1'b0, tie: 1'b0};
        pcode_next  = pcode_reg;
        plen_next   = plen_reg;
        psym_next   = psym_reg;
        pvld_next   = pvld_reg;
        perr_next   = perr_reg;
        tbl_wr_en   = 1'b0;
        tbl_rd_addr = addr_reg;

        res_valid_next  = res_valid_reg & res_stall;
        codeword_next   = codeword_reg;
        length_out_next = length_out_reg;
        symbol_out_next = symbol_out_reg;
        valid_res_next  = valid_res_reg;
        error_next      = error_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pcode_next = '0;
                    plen_next  = '0;
                    psym_next  = '0;
                    pvld_next  = 1'b0;
                    perr_next  = 1'b0;
                    state_next = S_DONE;
                    case (mode)
                        MODE_WRITE:
                        begin
                            tbl_wr_en = sym_ok;
                        end
                        MODE_READ:
                        begin
                            if (sym_ok)
                            begin
                                tbl_rd_addr = sym_idx;
                                sym_next    = sym_idx;
                                lookup_next = 1'b1;
                                state_next  = S_LKLEN;
                            end
                        end
                        MODE_DECODE:
                        begin
                            bits_next  = bits_new;
                            count_next = count_new;
                            if (count_new <= LEN_TOP)
                            begin
                                len_next    = count_new;
                                lookup_next = 1'b0;
                                pass_next   = 1'b0;
                                addr_next   = '0;
                                state_next  = S_WALK;
                            end
                            else if (count_new >= LIMIT)
                            begin
                                perr_next  = 1'b1;
                                bits_next  = '0;
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LKLEN:
            begin
                // Absent symbol answers with zeros
                len_next = tbl_rd_len;
                if (tbl_rd_len == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pass_next  = 1'b0;
                    addr_next  = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (pass_reg && u_hit)
                begin
                    plen_next  = len_reg;
                    psym_next  = SYM_W'(tbl_rd_idx);
                    pvld_next  = 1'b1;
                    bits_next  = '0;
                    count_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    // Issue the next entry and advance
                    tbl_rd_addr = addr_reg;
                    ctl_next    = '{op:    (pass_reg ? OP_RANK : OP_KRAFT),
                                    first: (!pass_reg && (addr_reg == '0)),
                                    tie:   lookup_reg};
                    addr_next   = addr_reg + IDX_W'(1);
                    if (addr_reg == LAST_IDX)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (pass_reg && u_hit)
                begin
                    plen_next  = len_reg;
                    psym_next  = SYM_W'(tbl_rd_idx);
                    pvld_next  = 1'b1;
                    bits_next  = '0;
                    count_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (lookup_reg)
                begin
                    pcode_next = u_acc & len_mask(len_reg);
                    plen_next  = len_reg;
                    pvld_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (!pass_reg)
                begin
                    // Turn the code space sum into the rank to find
                    ctl_next   = '{op: OP_NEG, first: 1'b0, tie: 1'b0};
                    pass_next  = 1'b1;
                    addr_next  = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    if (count_reg >= LIMIT)
                    begin
                        perr_next  = 1'b1;
                        bits_next  = '0;
                        count_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    codeword_next   = pcode_reg;
                    length_out_next = plen_reg;
                    symbol_out_next = psym_reg;
                    valid_res_next  = pvld_reg;
                    error_next      = perr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lookup_reg    <= 1'b0;
            pass_reg      <= 1'b0;
            addr_reg      <= '0;
            bits_reg      <= '0;
            count_reg     <= '0;
            ctl_reg       <= '{op: OP_IDLE, first: 1'b0, tie: 1'b0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lookup_reg    <= lookup_next;
            pass_reg      <= pass_next;
            addr_reg      <= addr_next;
            bits_reg      <= bits_next;
            count_reg     <= count_next;
            ctl_reg       <= ctl_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        sym_reg        <= sym_next;
        pcode_reg      <= pcode_next;
        plen_reg       <= plen_next;
        psym_reg       <= psym_next;
        pvld_reg       <= pvld_next;
        perr_reg       <= perr_next;
        codeword_reg   <= codeword_next;
        length_out_reg <= length_out_next;
        symbol_out_reg <= symbol_out_next;
        valid_res_reg  <= valid_res_next;
        error_reg      <= error_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign res_valid  = res_valid_reg;
    assign codeword   = codeword_reg;
    assign length_out = length_out_reg;
    assign symbol_out = symbol_out_reg;
    assign valid_res  = valid_res_reg;
    assign error      = error_reg;

    // A result never reports both a symbol and an error
    a_vld_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(valid_res && error))
        else $error("result flags both symbol and error");

    // Results without a symbol carry zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !valid_res) |-> (codeword == '0 && length_out == '0 && symbol_out == '0))
        else $error("empty result carries nonzero fields");

    // Decode count stays below the limit between requests
    a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg < LIMIT))
        else $error("decode count reached the limit without clearing");

    // Rank hits only during the second decode pass
    a_hit_pass: assert property (@(posedge clk) disable iff (!rst_n)
        u_hit |-> (pass_reg && !lookup_reg))
        else $error("rank hit outside the decode rank pass");

endmodule
